@@ rtl/absm_pkg.sv @@
// Package: codes, controller states and control structs of the boot slot manager.
package absm_pkg;

  localparam int SLOT_COUNT_DEF = 2;

  localparam logic [2:0] KIND_QUERY      = 3'd0;
  localparam logic [2:0] KIND_UNBOOTABLE = 3'd1;
  localparam logic [2:0] KIND_ACTIVE     = 3'd2;
  localparam logic [2:0] KIND_SUCCESSFUL = 3'd3;
  localparam logic [2:0] KIND_REBOOT     = 3'd4;

  localparam logic [1:0] STATUS_GRANTED     = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT     = 2'd1;
  localparam logic [1:0] STATUS_RUNNING     = 2'd2;
  localparam logic [1:0] STATUS_NOT_SUCCESS = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEARCH,
    ST_RESP
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_search;
    logic search_done;
  } ctl_sts_t;

endpackage

@@ rtl/absm_cmd_if.sv @@
// Interface: event item channel into the boot slot manager.
interface absm_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [7:0] slot;
  logic              update_requested;

  modport source (output valid, kind, slot, update_requested, input ready);
  modport sink   (input valid, kind, slot, update_requested, output ready);
endinterface

@@ rtl/absm_resp_if.sv @@
// Interface: result item channel out of the boot slot manager.
interface absm_resp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] current_slot;
  logic [3:0] active_slot;
  logic       slot_bootable;
  logic       slot_successful;
  logic       update_taken;

  modport source (output valid, status, current_slot, active_slot, slot_bootable,
                  slot_successful, update_taken, input ready);
  modport sink   (input valid, status, current_slot, active_slot, slot_bootable,
                  slot_successful, update_taken, output ready);
endinterface

@@ rtl/absm_ctrl.sv @@
// Controller: sequences accept, evaluation, rollback search and result hand-off.
module absm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  absm_pkg::ctl_sts_t sts,
  output absm_pkg::ctl_cmd_t cmd
);
  import absm_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = sts.need_search ? ST_SEARCH : ST_RESP;
      end
      ST_SEARCH: begin
        if (sts.search_done) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) state_next = in_fire ? ST_EVAL : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.load = in_fire;
  end

endmodule

@@ rtl/absm_datapath.sv @@
// Datapath: slot state, event evaluation, rollback search and result register.
module absm_datapath #(
  parameter int SLOT_COUNT = absm_pkg::SLOT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  absm_pkg::ctl_cmd_t cmd,
  output absm_pkg::ctl_sts_t sts,
  input  logic [2:0]         kind,
  input  logic [7:0]         slot,
  input  logic               update_requested,
  output logic [1:0]         status,
  output logic [3:0]         current_slot,
  output logic [3:0]         active_slot,
  output logic               slot_bootable,
  output logic               slot_successful,
  output logic               update_taken
);
  import absm_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  logic [IDX_W-1:0]      running;
  logic [IDX_W-1:0]      next_boot;
  logic [SLOT_COUNT-1:0] bootable;
  logic [SLOT_COUNT-1:0] successful;

  logic [2:0]            kind_q;
  logic [7:0]            slot_q;
  logic                  want_q;

  logic [IDX_W-1:0]      srch_idx;
  logic [IDX_W-1:0]      srch_cnt;

  logic                  slot_valid;
  logic [IDX_W-1:0]      tgt;
  logic [IDX_W-1:0]      running_next;
  logic [IDX_W-1:0]      next_boot_next;
  logic [SLOT_COUNT-1:0] bootable_next;
  logic [SLOT_COUNT-1:0] successful_next;
  logic [1:0]            status_next;
  logic                  taken_next;
  logic                  have_flags;
  logic [IDX_W-1:0]      addr;
  logic                  need_search;
  logic                  failed;
  logic                  try_update;
  logic                  rb_ok;
  logic [IDX_W-1:0]      rb_slot;

  logic                  srch_found;
  logic                  srch_last;

  assign slot_valid = slot_q < 8'(SLOT_COUNT);
  assign tgt        = slot_q[IDX_W-1:0];

  always_comb begin
    running_next    = running;
    next_boot_next  = next_boot;
    bootable_next   = bootable;
    successful_next = successful;
    status_next     = STATUS_GRANTED;
    taken_next      = 1'b0;
    have_flags      = 1'b1;
    addr            = running;
    need_search     = 1'b0;
    failed          = !successful[running];
    try_update      = 1'b0;
    rb_ok           = 1'b0;
    rb_slot         = running;
    case (kind_q)
      KIND_QUERY, KIND_UNBOOTABLE, KIND_ACTIVE: begin
        if (!slot_valid) begin
          status_next = STATUS_NO_SLOT;
          have_flags  = 1'b0;
        end else begin
          addr = tgt;
          if (kind_q != KIND_QUERY) begin
            if (tgt == running) begin
              status_next = STATUS_RUNNING;
            end else if (!successful[running]) begin
              status_next = STATUS_NOT_SUCCESS;
            end else if (kind_q == KIND_UNBOOTABLE) begin
              bootable_next[tgt]   = 1'b0;
              successful_next[tgt] = 1'b0;
            end else begin
              next_boot_next       = tgt;
              successful_next[tgt] = 1'b0;
              bootable_next[tgt]   = 1'b1;
            end
          end
        end
      end
      KIND_SUCCESSFUL: begin
        successful_next[running] = 1'b1;
        next_boot_next           = running;
      end
      KIND_REBOOT: begin
        if (failed) bootable_next[running] = 1'b0;
        try_update = want_q && slot_valid && bootable_next[tgt];
        if (try_update) begin
          if (failed) begin
            rb_ok   = tgt != next_boot;
            rb_slot = next_boot;
          end else if (tgt != running) begin
            rb_ok   = 1'b1;
            rb_slot = running;
          end else begin
            need_search = 1'b1;
          end
        end
        if (rb_ok) begin
          running_next         = tgt;
          next_boot_next       = rb_slot;
          successful_next[tgt] = 1'b0;
          taken_next           = 1'b1;
        end else if (!need_search) begin
          running_next   = next_boot;
          next_boot_next = failed ? next_boot : running;
        end
        addr = running_next;
      end
      default: begin
        addr = running;
      end
    endcase
  end

  assign srch_found = successful[srch_idx];
  assign srch_last  = srch_cnt == IDX_W'(1);

  assign sts.need_search = need_search;
  assign sts.search_done = srch_found || srch_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= '0;
      next_boot  <= '0;
      bootable   <= '1;
      successful <= '1;
    end else if (cmd.eval && !need_search) begin
      running    <= running_next;
      next_boot  <= next_boot_next;
      bootable   <= bootable_next;
      successful <= successful_next;
    end else if (cmd.step) begin
      if (srch_found) begin
        next_boot            <= srch_idx;
        successful[running]  <= 1'b0;
      end else if (srch_last) begin
        running   <= next_boot;
        next_boot <= running;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      slot_q <= slot;
      want_q <= update_requested;
    end
    if (cmd.eval) begin
      srch_idx <= (tgt == '0) ? IDX_W'(SLOT_COUNT - 1) : tgt - 1'b1;
      srch_cnt <= IDX_W'(SLOT_COUNT - 1);
    end else if (cmd.step) begin
      srch_idx <= (srch_idx == '0) ? IDX_W'(SLOT_COUNT - 1) : srch_idx - 1'b1;
      srch_cnt <= srch_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && !need_search) begin
      status          <= status_next;
      current_slot    <= 4'(running_next);
      active_slot     <= 4'(next_boot_next);
      slot_bootable   <= have_flags && bootable_next[addr];
      slot_successful <= have_flags && successful_next[addr];
      update_taken    <= taken_next;
    end else if (cmd.step && srch_found) begin
      status          <= STATUS_GRANTED;
      current_slot    <= 4'(running);
      active_slot     <= 4'(srch_idx);
      slot_bootable   <= bootable[running];
      slot_successful <= 1'b0;
      update_taken    <= 1'b1;
    end else if (cmd.step && srch_last) begin
      status          <= STATUS_GRANTED;
      current_slot    <= 4'(next_boot);
      active_slot     <= 4'(running);
      slot_bootable   <= bootable[next_boot];
      slot_successful <= successful[next_boot];
      update_taken    <= 1'b0;
    end
  end

endmodule

@@ rtl/ab_boot_slot_manager.sv @@
// Top level: A/B boot slot manager with rollback, controller plus datapath.
//
//   channel  role    moves
//   cmd      sink    event item: kind, slot, update_requested
//   resp     source  result item: status, slots, flags of addressed slot, update_taken
//
// An item is accepted, then evaluated; evaluation loads the result register unless a search is needed.
// A reboot that updates to the confirmed running slot walks the slots for a rollback
// candidate, one slot per cycle.
// Reset puts slot 0 as running and active with every slot bootable and successful.
// A result holds until taken; the next item is accepted in the cycle the result leaves.
module ab_boot_slot_manager #(
  parameter int SLOT_COUNT = absm_pkg::SLOT_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  absm_cmd_if.sink   cmd,
  absm_resp_if.source resp
);
  import absm_pkg::*;

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  absm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (resp.valid),
    .out_ready (resp.ready),
    .sts       (ctl_sts),
    .cmd       (ctl_cmd)
  );

  absm_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (ctl_cmd),
    .sts              (ctl_sts),
    .kind             (cmd.kind),
    .slot             (cmd.slot),
    .update_requested (cmd.update_requested),
    .status           (resp.status),
    .current_slot     (resp.current_slot),
    .active_slot      (resp.active_slot),
    .slot_bootable    (resp.slot_bootable),
    .slot_successful  (resp.slot_successful),
    .update_taken     (resp.update_taken)
  );

endmodule

@@ tb/sv/boot_slot_tracker.sv @@
// Watches both channels, tracks boot slot state from accepted events and checks each result.
module boot_slot_tracker #(
  parameter int SLOTS = absm_pkg::SLOT_COUNT_DEF
) (
  input  logic  clk,
  input  logic  rst,
  absm_cmd_if   cmd,
  absm_resp_if  resp,
  output int    fails,
  output int    pending,
  output int    checked,
  output int    adopted,
  output int    refused
);
  import absm_pkg::*;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] cur;
    logic [3:0] act;
    logic       bootable;
    logic       successful;
    logic       taken;
  } slot_report_t;

  int           run_slot;
  int           queued_slot;
  logic         boot_ok   [SLOTS];
  logic         confirmed [SLOTS];
  slot_report_t expected_reports[$];

  function automatic logic find_rollback(input int tgt, input logic failed, input int prev_cur,
                                         input int prev_next, output int fb);
    int i;
    fb = 0;
    if (failed) begin
      if (tgt == prev_next) return 1'b0;
      fb = prev_next;
      return 1'b1;
    end
    if (tgt != prev_cur) begin
      fb = prev_cur;
      return 1'b1;
    end
    for (i = SLOTS - 1; i > 0; i--) begin
      if (confirmed[(tgt + i) % SLOTS]) begin
        fb = (tgt + i) % SLOTS;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic apply_boot_event(input logic [2:0] kind, input logic [7:0] raw,
                                  input logic want);
    int           addr;
    int           prev_cur;
    int           prev_next;
    int           fb;
    logic         in_range;
    logic         failed;
    logic         flags_known;
    slot_report_t rep;
    rep         = '0;
    rep.status  = STATUS_GRANTED;
    in_range    = raw < SLOTS;
    flags_known = 1'b1;
    addr        = run_slot;
    case (kind)
      KIND_QUERY, KIND_UNBOOTABLE, KIND_ACTIVE: begin
        if (!in_range) begin
          rep.status  = STATUS_NO_SLOT;
          flags_known = 1'b0;
        end else begin
          addr = int'(raw);
          if (kind != KIND_QUERY) begin
            if (addr == run_slot) begin
              rep.status = STATUS_RUNNING;
            end else if (!confirmed[run_slot]) begin
              rep.status = STATUS_NOT_SUCCESS;
            end else if (kind == KIND_UNBOOTABLE) begin
              boot_ok[addr]   = 1'b0;
              confirmed[addr] = 1'b0;
            end else begin
              queued_slot     = addr;
              confirmed[addr] = 1'b0;
              boot_ok[addr]   = 1'b1;
            end
          end
        end
      end
      KIND_SUCCESSFUL: begin
        confirmed[run_slot] = 1'b1;
        queued_slot         = run_slot;
      end
      KIND_REBOOT: begin
        prev_cur  = run_slot;
        prev_next = queued_slot;
        failed    = !confirmed[prev_cur];
        if (failed) boot_ok[prev_cur] = 1'b0;
        if (want && in_range && boot_ok[raw] &&
            find_rollback(int'(raw), failed, prev_cur, prev_next, fb)) begin
          run_slot       = int'(raw);
          queued_slot    = fb;
          confirmed[raw] = 1'b0;
          rep.taken      = 1'b1;
        end else begin
          run_slot    = prev_next;
          queued_slot = failed ? prev_next : prev_cur;
        end
      end
      default: ;
    endcase
    if (kind > KIND_ACTIVE) addr = run_slot;
    rep.cur        = 4'(run_slot);
    rep.act        = 4'(queued_slot);
    rep.bootable   = flags_known && boot_ok[addr];
    rep.successful = flags_known && confirmed[addr];
    expected_reports.push_back(rep);
  endtask

  always @(posedge clk) begin
    slot_report_t got;
    slot_report_t want_rep;
    if (rst) begin
      run_slot    = 0;
      queued_slot = 0;
      for (int s = 0; s < SLOTS; s++) begin
        boot_ok[s]   = 1'b1;
        confirmed[s] = 1'b1;
      end
      expected_reports.delete();
      fails   = 0;
      checked = 0;
      adopted = 0;
      refused = 0;
    end else begin
      if (resp.valid && resp.ready) begin
        got = '{resp.status, resp.current_slot, resp.active_slot, resp.slot_bootable,
                resp.slot_successful, resp.update_taken};
        if (expected_reports.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result item: status %0d cur %0d act %0d", got.status,
                     got.cur, got.act);
        end else begin
          want_rep = expected_reports.pop_front();
          checked++;
          if (got.taken) adopted++;
          if (got.status == STATUS_RUNNING || got.status == STATUS_NOT_SUCCESS) refused++;
          if (got != want_rep) begin
            fails++;
            if (fails <= 10)
              $display({"result %0d mismatch: expected status %0d cur %0d act %0d boot %b ",
                        "good %b upd %b, got status %0d cur %0d act %0d boot %b good %b upd %b"},
                       checked, want_rep.status, want_rep.cur, want_rep.act,
                       want_rep.bootable, want_rep.successful, want_rep.taken, got.status,
                       got.cur, got.act, got.bootable, got.successful, got.taken);
          end
        end
      end
      if (cmd.valid && cmd.ready) apply_boot_event(cmd.kind, cmd.slot, cmd.update_requested);
    end
    pending = expected_reports.size();
  end

endmodule

@@ tb/sv/ab_boot_slot_manager_tb.sv @@
// Top of the boot slot manager testbench: clock, reset, event stimulus, result stalls, verdict.
module ab_boot_slot_manager_tb;
  import absm_pkg::*;

  localparam int N_SLOTS       = SLOT_COUNT_DEF;
  localparam int RANDOM_EVENTS = 900;
  localparam int HOLD_AT       = 300;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_AT      = 600;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   checked;
  int   adopted;
  int   refused;
  int   sent;
  int   taken;
  int   rx_wait;

  absm_cmd_if  cmd_ch ();
  absm_resp_if resp_ch ();

  ab_boot_slot_manager #(.SLOT_COUNT(N_SLOTS)) DUT (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_ch),
    .resp (resp_ch)
  );

  boot_slot_tracker #(.SLOTS(N_SLOTS)) tracker (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .resp    (resp_ch),
    .fails   (fails),
    .pending (pending),
    .checked (checked),
    .adopted (adopted),
    .refused (refused)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("ab_boot_slot_manager regression: fail");
    $finish;
  end

  function automatic int tx_gap(input int idx);
    if (idx >= HOLD_AT - 10 && idx < HOLD_AT + 80) return 0;
    if ((idx / 50) % 4 == 3) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic int rx_gap(input int n);
    if (n == HOLD_AT) return HOLD_CYCLES;
    if ((n / 64) % 3 == 2) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send_event(input logic [2:0] kind, input logic signed [7:0] slot,
                            input logic upd);
    int gap;
    gap = tx_gap(sent);
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid            = 1'b1;
    cmd_ch.kind             = kind;
    cmd_ch.slot             = slot;
    cmd_ch.update_requested = upd;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain_events;
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random_event;
    logic [2:0]        kind;
    logic signed [7:0] slot;
    logic              upd;
    int                r;
    r = $urandom_range(0, 99);
    if (r < 25)      kind = KIND_REBOOT;
    else if (r < 45) kind = KIND_SUCCESSFUL;
    else if (r < 65) kind = KIND_ACTIVE;
    else if (r < 77) kind = KIND_UNBOOTABLE;
    else if (r < 94) kind = KIND_QUERY;
    else             kind = KIND_REBOOT + 3'($urandom_range(1, 3));
    if ($urandom_range(0, 99) < 85) slot = 8'($urandom_range(0, N_SLOTS - 1));
    else                            slot = 8'($urandom);
    upd = $urandom_range(0, 9) < 7;
    send_event(kind, slot, upd);
  endtask

  initial begin
    resp_ch.ready = 1'b0;
    taken         = 0;
    rx_wait       = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        resp_ch.ready = 1'b0;
      end else if (rx_wait > 0) begin
        resp_ch.ready = 1'b0;
        rx_wait--;
      end else begin
        resp_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (!rst && resp_ch.valid && resp_ch.ready) begin
        taken++;
        rx_wait = rx_gap(taken);
      end
    end
  end

  initial begin
    cmd_ch.valid            = 1'b0;
    cmd_ch.kind             = KIND_QUERY;
    cmd_ch.slot             = '0;
    cmd_ch.update_requested = 1'b0;
    sent                    = 0;
    rst                     = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_event(KIND_QUERY, 8'sd0, 1'b0);
    send_event(KIND_QUERY, 8'(N_SLOTS - 1), 1'b1);
    send_event(KIND_QUERY, 8'sh80, 1'b0);
    send_event(KIND_QUERY, 8'sh7F, 1'b1);
    send_event(KIND_QUERY, 8'(N_SLOTS), 1'b0);
    send_event(KIND_REBOOT + 3'd1, 8'($urandom), 1'b1);
    send_event(KIND_REBOOT + 3'd2, 8'($urandom), 1'b0);
    send_event(KIND_REBOOT + 3'd3, 8'($urandom), 1'b1);
    send_event(KIND_UNBOOTABLE, 8'sd0, 1'b0);
    send_event(KIND_ACTIVE, 8'shFF, 1'b0);
    send_event(KIND_ACTIVE, 8'sd1, 1'b0);
    send_event(KIND_REBOOT, 8'sd1, 1'b0);
    send_event(KIND_UNBOOTABLE, 8'sd0, 1'b0);
    send_event(KIND_ACTIVE, 8'sd0, 1'b0);
    send_event(KIND_SUCCESSFUL, 8'sd0, 1'b0);
    send_event(KIND_REBOOT, 8'sd1, 1'b1);
    send_event(KIND_REBOOT, 8'sd0, 1'b1);
    send_event(KIND_SUCCESSFUL, 8'shFF, 1'b1);
    send_event(KIND_REBOOT, 8'sd1, 1'b1);
    send_event(KIND_UNBOOTABLE, 8'sd1, 1'b0);
    send_event(KIND_REBOOT, 8'sd0, 1'b1);
    send_event(KIND_ACTIVE, 8'sd1, 1'b0);
    send_event(KIND_REBOOT, 8'sd1, 1'b1);
    send_event(KIND_REBOOT, 8'shFF, 1'b1);
    send_event(KIND_SUCCESSFUL, 8'sh7F, 1'b0);
    drain_events;

    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i == DRAIN_AT) drain_events;
      send_random_event;
    end
    drain_events;
    repeat (10) @(negedge clk);

    $display("covered %0d events over %0d slots, %0d results checked, %0d failures",
             sent, N_SLOTS, checked, fails);
    $display("%0d updates adopted, %0d commands refused, one result stall of %0d cycles",
             adopted, refused, HOLD_CYCLES);
    if (fails == 0 && pending == 0) begin
      $display("ab_boot_slot_manager regression: pass");
    end else begin
      $display("ab_boot_slot_manager regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/absm_pkg.sv
rtl/absm_cmd_if.sv
rtl/absm_resp_if.sv
rtl/absm_ctrl.sv
rtl/absm_datapath.sv
rtl/ab_boot_slot_manager.sv
tb/sv/boot_slot_tracker.sv
tb/sv/ab_boot_slot_manager_tb.sv
